[rtl/gradient_noise_2d_top_macros.svh]
// ----------------------------------------------------------------------------
// gradient_noise_2d_top_macros.svh
// Assertion macros used by the rtl checker file.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_TOP_MACROS_SVH
`define GRADIENT_NOISE_2D_TOP_MACROS_SVH

// clocked assertion, off while reset is high
`define GN2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define GN2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gn2_pkg.sv]
// ----------------------------------------------------------------------------
// gn2_pkg
// Types, constants and table functions of the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn2_pkg;

  localparam int PHASE_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 32;
  localparam int GRAD_W  = 16;
  localparam int OUT_W   = 16;
  localparam int DOT_FRAC = 24;
  localparam int DOT_W   = DOT_FRAC + 3;
  localparam int N_STAGES = 15;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  localparam int MAG_W       = 24;
  localparam int CLAMP_Q24   = 11744051;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] SCALE_RECIP =
    RECIP_W'((64'd1 << 39) / 64'd11744051);
  localparam int NUM_W  = MAG_W + 16;
  localparam int TWOC_W = 25;
  localparam logic [TWOC_W-1:0] TWO_CLAMP = TWOC_W'(2 * CLAMP_Q24);
  localparam int QC_W   = 16;

  localparam longint unsigned SC1 = 64'd1686629713;
  localparam longint unsigned SC3 = 64'd693598668;
  localparam longint unsigned SC5 = 64'd85569306;
  localparam longint unsigned SC7 = 64'd5026995;
  localparam longint unsigned SC9 = 64'd172272;

  function automatic logic [31:0] rotl16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // sin(pi/2 * m/Q) in Q1.15, Q = 2^(phase_bits-2)
  function automatic logic [GRAD_W-1:0] quarter_sine(int unsigned m, int phase_bits);
    longint unsigned u, u2, t, s, r;
    u  = 64'(m) << (30 - (phase_bits - 2));
    u2 = (u * u) >> 30;
    t  = SC9;
    t  = SC7 - ((u2 * t) >> 30);
    t  = SC5 - ((u2 * t) >> 30);
    t  = SC3 - ((u2 * t) >> 30);
    t  = SC1 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return GRAD_W'(r);
  endfunction

endpackage

[rtl/gn2_corner.sv]
// ----------------------------------------------------------------------------
// gn2_corner
// Lattice hash, gradient table lookup and dot product for one cell corner.
// ----------------------------------------------------------------------------
module gn2_corner #(
  parameter int PHASE_BITS = gn2_pkg::PHASE_BITS_DEF,
  parameter int FRAC_BITS  = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [5:0]                         en,
  input  logic [gn2_pkg::COORD_W-1:0]        cx,
  input  logic [gn2_pkg::COORD_W-1:0]        cy,
  input  logic signed [FRAC_BITS:0]          dx,
  input  logic signed [FRAC_BITS:0]          dy,
  output logic signed [gn2_pkg::DOT_W-1:0]   n
);
  import gn2_pkg::*;

  localparam int QS  = 1 << (PHASE_BITS - 2);
  localparam int PW  = FRAC_BITS + 1 + GRAD_W;
  localparam int SW  = PW + 1;
  localparam int SH  = FRAC_BITS + 15 - DOT_FRAC;

  logic [GRAD_W-1:0] qrom [QS+1];

  genvar gi;
  generate
    for (gi = 0; gi <= QS; gi++) begin : g_rom
      assign qrom[gi] = quarter_sine(gi, PHASE_BITS);
    end
  endgenerate

  logic [31:0] a1, a2, b2, h3, cy1;
  logic signed [FRAC_BITS:0] dx1, dy1, dx2, dy2, dx3, dy3, dx4, dy4;
  logic signed [GRAD_W-1:0] gs4, gc4;
  logic signed [PW-1:0] px5, py5;
  logic signed [SW-1:0] sum;
  logic signed [DOT_W-1:0] n_next;

  logic [PHASE_BITS-1:0]   ph [2];
  logic [1:0]              quad [2];
  logic [PHASE_BITS-2:0]   mi [2];
  logic signed [GRAD_W-1:0] gv [2];

  always_comb begin
    ph[0] = h3[31 -: PHASE_BITS];
    ph[1] = h3[31 -: PHASE_BITS] + PHASE_BITS'(QS);
    for (int j = 0; j < 2; j++) begin
      quad[j] = ph[j][PHASE_BITS-1 -: 2];
      if (quad[j][0]) begin
        mi[j] = (PHASE_BITS-1)'(QS) - {1'b0, ph[j][PHASE_BITS-3:0]};
      end else begin
        mi[j] = {1'b0, ph[j][PHASE_BITS-3:0]};
      end
      gv[j] = quad[j][1] ? -$signed(qrom[mi[j]]) : $signed(qrom[mi[j]]);
    end
  end

  assign sum = SW'(px5) + SW'(py5);

  generate
    if (SH >= 0) begin : g_shr
      assign n_next = DOT_W'(sum >>> SH);
    end else begin : g_shl
      assign n_next = DOT_W'(sum) <<< (DOT_FRAC - FRAC_BITS - 15);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1  <= 32'(cx * HASH_M1);
      cy1 <= cy;
      dx1 <= dx;
      dy1 <= dy;
    end
    if (en[1]) begin
      b2  <= 32'((cy1 ^ rotl16(a1)) * HASH_M2);
      a2  <= a1;
      dx2 <= dx1;
      dy2 <= dy1;
    end
    if (en[2]) begin
      h3  <= 32'((a2 ^ rotl16(b2)) * HASH_M3);
      dx3 <= dx2;
      dy3 <= dy2;
    end
    if (en[3]) begin
      gs4 <= gv[0];
      gc4 <= gv[1];
      dx4 <= dx3;
      dy4 <= dy3;
    end
    if (en[4]) begin
      px5 <= PW'(dx4 * gc4);
      py5 <= PW'(dy4 * gs4);
    end
    if (en[5]) begin
      n <= n_next;
    end
  end

endmodule

[rtl/gn2_weight.sv]
// ----------------------------------------------------------------------------
// gn2_weight
// Cubic smoothstep weights for x and y, delayed to meet the corner results.
// ----------------------------------------------------------------------------
module gn2_weight #(
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [5:0]           en,
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  output logic [FRAC_BITS:0]   wx,
  output logic [FRAC_BITS:0]   wy
);
  import gn2_pkg::*;

  localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS+2)'(3) << FRAC_BITS;

  logic [2*FRAC_BITS-1:0] sqx, sqy;
  logic [FRAC_BITS-1:0]   tx1, ty1, t2x1, t2y1;
  logic [FRAC_BITS+1:0]   kx, ky;
  logic [2*FRAC_BITS+1:0] px, py;
  logic [FRAC_BITS:0]     wxd [4];
  logic [FRAC_BITS:0]     wyd [4];

  assign sqx = fx * fx;
  assign sqy = fy * fy;
  assign kx  = THREE - {1'b0, tx1, 1'b0};
  assign ky  = THREE - {1'b0, ty1, 1'b0};
  assign px  = (2*FRAC_BITS+2)'(t2x1) * (2*FRAC_BITS+2)'(kx);
  assign py  = (2*FRAC_BITS+2)'(t2y1) * (2*FRAC_BITS+2)'(ky);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t2x1 <= sqx[2*FRAC_BITS-1:FRAC_BITS];
      t2y1 <= sqy[2*FRAC_BITS-1:FRAC_BITS];
      tx1  <= fx;
      ty1  <= fy;
    end
    if (en[1]) begin
      wxd[0] <= px[2*FRAC_BITS:FRAC_BITS];
      wyd[0] <= py[2*FRAC_BITS:FRAC_BITS];
    end
    for (int i = 1; i < 4; i++) begin
      if (en[i+1]) begin
        wxd[i] <= wxd[i-1];
        wyd[i] <= wyd[i-1];
      end
    end
    if (en[5]) begin
      wx <= wxd[3];
      wy <= wyd[3];
    end
  end

endmodule

[rtl/gn2_mix.sv]
// ----------------------------------------------------------------------------
// gn2_mix
// Bilinear blend of the corner values, clamp and rescale to Q2.14.
// ----------------------------------------------------------------------------
module gn2_mix #(
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [7:0]                         en,
  input  logic signed [gn2_pkg::DOT_W-1:0]   n00,
  input  logic signed [gn2_pkg::DOT_W-1:0]   n10,
  input  logic signed [gn2_pkg::DOT_W-1:0]   n01,
  input  logic signed [gn2_pkg::DOT_W-1:0]   n11,
  input  logic [FRAC_BITS:0]                 wx,
  input  logic [FRAC_BITS:0]                 wy,
  output logic signed [gn2_pkg::OUT_W-1:0]   noise_value
);
  import gn2_pkg::*;

  localparam int DFW = DOT_W + 1;
  localparam int PW  = DFW + FRAC_BITS + 2;

  logic signed [DFW-1:0]   d0, d1, d2;
  logic signed [FRAC_BITS+1:0] swx;
  logic signed [PW-1:0]    p0, p1, p2;
  logic signed [DOT_W-1:0] a0, a1, lo8, hi8, lo9, v_next;
  logic [FRAC_BITS:0]      wy7, wy8;
  logic [MAG_W-1:0]        m10, m11;
  logic                    neg10, neg11, neg12, neg13;
  logic                    neg_next;
  logic [MAG_W-1:0]        m_next;
  logic [NUM_W-1:0]        mr11, num12;
  logic [QC_W-1:0]         qc12, qc13, q_next;
  logic [NUM_W:0]          prodq;
  logic signed [NUM_W+1:0] rem13;

  assign swx = $signed({1'b0, wx});
  assign d0  = DFW'(n10) - DFW'(n00);
  assign d1  = DFW'(n11) - DFW'(n01);
  assign d2  = DFW'(hi8) - DFW'(lo8);

  assign v_next = lo9 + DOT_W'(p2 >>> FRAC_BITS);

  always_comb begin
    if (v_next > $signed(DOT_W'(CLAMP_Q24))) begin
      neg_next = 1'b0;
      m_next   = MAG_W'(CLAMP_Q24);
    end else if (v_next < -$signed(DOT_W'(CLAMP_Q24))) begin
      neg_next = 1'b1;
      m_next   = MAG_W'(CLAMP_Q24);
    end else begin
      neg_next = v_next[DOT_W-1];
      m_next   = MAG_W'(v_next[DOT_W-1] ? -v_next : v_next);
    end
  end

  assign prodq = (NUM_W+1)'(qc12) * (NUM_W+1)'(TWO_CLAMP);

  always_comb begin
    if (rem13 < 0) begin
      q_next = qc13 - QC_W'(1);
    end else if (rem13 >= $signed((NUM_W+2)'(TWO_CLAMP))) begin
      q_next = qc13 + QC_W'(1);
    end else begin
      q_next = qc13;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0  <= PW'(d0 * swx);
      p1  <= PW'(d1 * swx);
      a0  <= n00;
      a1  <= n01;
      wy7 <= wy;
    end
    if (en[1]) begin
      lo8 <= a0 + DOT_W'(p0 >>> FRAC_BITS);
      hi8 <= a1 + DOT_W'(p1 >>> FRAC_BITS);
      wy8 <= wy7;
    end
    if (en[2]) begin
      p2  <= PW'(d2 * $signed({1'b0, wy8}));
      lo9 <= lo8;
    end
    if (en[3]) begin
      m10   <= m_next;
      neg10 <= neg_next;
    end
    if (en[4]) begin
      mr11  <= NUM_W'(m10) * NUM_W'(SCALE_RECIP);
      m11   <= m10;
      neg11 <= neg10;
    end
    if (en[5]) begin
      qc12  <= QC_W'(((mr11 >> RECIP_SHIFT) + NUM_W'(1)) >> 1);
      num12 <= {m11, 16'b0} >> 1;
      neg12 <= neg11;
    end
    if (en[6]) begin
      rem13 <= $signed({2'b0, num12 + NUM_W'(CLAMP_Q24)}) - $signed({1'b0, prodq});
      qc13  <= qc12;
      neg13 <= neg12;
    end
    if (en[7]) begin
      noise_value <= neg13 ? -$signed(q_next) : $signed(q_next);
    end
  end

endmodule

[rtl/gradient_noise_2d_top.sv]
// ----------------------------------------------------------------------------
// gradient_noise_2d_top
// 2D gradient noise: Q16.16 point in, Q2.14 noise value out.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------
//  coord   | coord_valid / coord_ready  | coord_x, coord_y
//  noise   | noise_valid / noise_ready  | noise_value
//
//  One point per cycle while noise_ready holds, through a 15-stage pipeline.
//  Each hash multiplier owns a stage; so do the x and the y blend multiplies.
//  Reset clears the stage valid bits only.
//  A stage advances when it is empty or the stage after it advances,
//  so bubbles close up during a stall and nothing is dropped.
// ----------------------------------------------------------------------------
module gradient_noise_2d_top #(
  parameter int PHASE_BITS = gn2_pkg::PHASE_BITS_DEF,
  parameter int FRAC_BITS  = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              coord_valid,
  output logic                              coord_ready,
  input  logic signed [gn2_pkg::COORD_W-1:0] coord_x,
  input  logic signed [gn2_pkg::COORD_W-1:0] coord_y,
  output logic                              noise_valid,
  input  logic                              noise_ready,
  output logic signed [gn2_pkg::OUT_W-1:0]  noise_value
);
  import gn2_pkg::*;

  logic [N_STAGES-1:0] vld;
  logic [N_STAGES:0]   en;

  logic [COORD_W-1:0]    cx0, cx1, cy0, cy1;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic signed [FRAC_BITS:0] dx0, dx1, dy0, dy1;
  logic signed [DOT_W-1:0]   n00, n10, n01, n11;
  logic [FRAC_BITS:0]    wx, wy;

  always_comb begin
    en[N_STAGES] = noise_ready;
    for (int i = N_STAGES - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign coord_ready = en[0];
  assign noise_valid = vld[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= coord_valid;
      for (int i = 1; i < N_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cx0 <= COORD_W'(coord_x >>> FRAC_BITS);
      cx1 <= COORD_W'(coord_x >>> FRAC_BITS) + COORD_W'(1);
      cy0 <= COORD_W'(coord_y >>> FRAC_BITS);
      cy1 <= COORD_W'(coord_y >>> FRAC_BITS) + COORD_W'(1);
      fx  <= coord_x[FRAC_BITS-1:0];
      fy  <= coord_y[FRAC_BITS-1:0];
    end
  end

  assign dx0 = $signed({1'b0, fx});
  assign dx1 = $signed({1'b1, fx});
  assign dy0 = $signed({1'b0, fy});
  assign dy1 = $signed({1'b1, fy});

  gn2_corner #(.PHASE_BITS(PHASE_BITS), .FRAC_BITS(FRAC_BITS)) u_c00 (
    .clk(clk), .en(en[6:1]), .cx(cx0), .cy(cy0), .dx(dx0), .dy(dy0), .n(n00));
  gn2_corner #(.PHASE_BITS(PHASE_BITS), .FRAC_BITS(FRAC_BITS)) u_c10 (
    .clk(clk), .en(en[6:1]), .cx(cx1), .cy(cy0), .dx(dx1), .dy(dy0), .n(n10));
  gn2_corner #(.PHASE_BITS(PHASE_BITS), .FRAC_BITS(FRAC_BITS)) u_c01 (
    .clk(clk), .en(en[6:1]), .cx(cx0), .cy(cy1), .dx(dx0), .dy(dy1), .n(n01));
  gn2_corner #(.PHASE_BITS(PHASE_BITS), .FRAC_BITS(FRAC_BITS)) u_c11 (
    .clk(clk), .en(en[6:1]), .cx(cx1), .cy(cy1), .dx(dx1), .dy(dy1), .n(n11));

  gn2_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk(clk), .en(en[6:1]), .fx(fx), .fy(fy), .wx(wx), .wy(wy));

  gn2_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk(clk), .en(en[14:7]),
    .n00(n00), .n10(n10), .n01(n01), .n11(n11),
    .wx(wx), .wy(wy), .noise_value(noise_value));

endmodule

[rtl/gn2_checker.sv]
// ----------------------------------------------------------------------------
// gn2_checker
// Port-level checks on the gradient noise top level.
// ----------------------------------------------------------------------------
`include "gradient_noise_2d_top_macros.svh"

module gn2_props (
  input logic                               clk,
  input logic                               rst,
  input logic                               coord_ready,
  input logic                               noise_valid,
  input logic                               noise_ready,
  input logic signed [gn2_pkg::OUT_W-1:0]   noise_value
);
  import gn2_pkg::*;

  `GN2_ASSERT(a_range, noise_valid |-> (noise_value <= 16'sd16384 && noise_value >= -16'sd16384), "noise_value out of range")
  `GN2_ASSERT_ALWAYS(a_rst_empty, rst |=> !noise_valid, "noise_valid after reset")
  `GN2_ASSERT(a_hold, noise_valid && !noise_ready |=> noise_valid && $stable(noise_value), "stalled transaction changed")
  `GN2_ASSERT_ALWAYS(a_flow, noise_ready |-> coord_ready, "input blocked while output drains")

endmodule

bind gradient_noise_2d_top gn2_props u_gn2_props (.*);

[sim/gn2_checker.sv]
// ----------------------------------------------------------------------------
// gn2_checker
// Watches both channels of the 2D gradient noise block, computes the noise
// value of every accepted point and compares it with the delivered result.
// ----------------------------------------------------------------------------
module gn2_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        coord_valid,
  input  logic        coord_ready,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic        noise_valid,
  input  logic        noise_ready,
  input  logic [15:0] noise_value,
  output int          fail_count,
  output int          pending
);
  localparam int PB = gn2_pkg::PHASE_BITS_DEF;
  localparam int FB = gn2_pkg::FRAC_BITS_DEF;
  localparam longint CLAMP = 64'd11744051;

  logic [15:0] noise_q[$];

  function automatic logic [31:0] swap_halves(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] corner_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a, b;
    a = cx * 32'd3284157443;
    b = cy ^ swap_halves(a);
    b = b * 32'd1911520717;
    a = a ^ swap_halves(b);
    a = a * 32'd2048419325;
    return a;
  endfunction

  function automatic longint qsine(longint unsigned m);
    longint unsigned u, u2, t, s, r;
    u  = m << (30 - (PB - 2));
    u2 = (u * u) >> 30;
    t  = 64'd172272;
    t  = 64'd5026995 - ((u2 * t) >> 30);
    t  = 64'd85569306 - ((u2 * t) >> 30);
    t  = 64'd693598668 - ((u2 * t) >> 30);
    t  = 64'd1686629713 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return longint'(r);
  endfunction

  function automatic longint sine_of(int unsigned k);
    int unsigned idx, quad, r, qs;
    longint v;
    qs   = 1 << (PB - 2);
    idx  = k & ((1 << PB) - 1);
    quad = idx >> (PB - 2);
    r    = idx & (qs - 1);
    v    = (quad == 0 || quad == 2) ? qsine(r) : qsine(qs - r);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic longint floor_div(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint grad_dot(logic [31:0] cx, logic [31:0] cy,
                                      longint dx, longint dy);
    int unsigned k;
    k = corner_hash(cx, cy) >> (32 - PB);
    return floor_div(dx * sine_of(k + (1 << (PB - 2))) + dy * sine_of(k),
                     FB + 15 - 24);
  endfunction

  function automatic longint fade(longint t);
    longint t2;
    t2 = (t * t) >> FB;
    return (t2 * ((longint'(3) << FB) - 2 * t)) >> FB;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + floor_div((b - a) * w, FB);
  endfunction

  function automatic logic [15:0] noise_of(logic [31:0] x, logic [31:0] y);
    logic [31:0] cx, cy;
    longint fx, fy, one, wx, wy, lo, hi, v, m, q;
    cx  = $signed(x) >>> FB;
    cy  = $signed(y) >>> FB;
    fx  = x & ((1 << FB) - 1);
    fy  = y & ((1 << FB) - 1);
    one = longint'(1) << FB;
    wx  = fade(fx);
    wy  = fade(fy);
    lo  = mix(grad_dot(cx, cy, fx, fy), grad_dot(cx + 1, cy, fx - one, fy), wx);
    hi  = mix(grad_dot(cx, cy + 1, fx, fy - one),
              grad_dot(cx + 1, cy + 1, fx - one, fy - one), wx);
    v   = mix(lo, hi, wy);
    if (v > CLAMP) v = CLAMP;
    if (v < -CLAMP) v = -CLAMP;
    m = (v < 0) ? -v : v;
    q = (m * 32768 + CLAMP) / (2 * CLAMP);
    return 16'((v < 0) ? -q : q);
  endfunction

  assign pending = noise_q.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (coord_valid && coord_ready) noise_q.push_back(noise_of(coord_x, coord_y));
      if (noise_valid && noise_ready) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected transaction, actual %0d", $signed(noise_value));
          fail_count <= fail_count + 1;
        end else begin
          logic [15:0] exp_v;
          exp_v = noise_q.pop_front();
          if (exp_v !== noise_value) begin
            $error("noise_value: expected %0d actual %0d", $signed(exp_v),
                   $signed(noise_value));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives fixed points, then random ones in bursts, into the 2D gradient
// noise block, stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int N_RAND = 1250;
  localparam int WD_LIMIT = 2000;

  logic clk = 0, rst = 1;
  logic coord_valid = 0, noise_ready = 0;
  logic signed [31:0] coord_x = 0, coord_y = 0;
  logic coord_ready, noise_valid;
  logic signed [15:0] noise_value;
  int fail_count, pending, idle_cycles = 0;
  logic [31:0] dir_x[$], dir_y[$];

  always #5 clk = ~clk;

  gradient_noise_2d_top u_top (.*);

  gn2_checker u_chk (.clk, .rst, .coord_valid, .coord_ready, .coord_x, .coord_y,
    .noise_valid, .noise_ready, .noise_value, .fail_count, .pending);

  always @(posedge clk) begin
    if (rst) noise_ready <= 0;
    else case ($urandom_range(0, 3))
      0: noise_ready <= 0;
      1: noise_ready <= ($urandom_range(0, 3) != 0);
      default: noise_ready <= 1;
    endcase
  end

  always @(posedge clk) begin
    if ((coord_valid && coord_ready) || (noise_valid && noise_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000 * $urandom_range(0, 8);
      2: return {16'($urandom_range(0, 3)) - 16'd2, 16'($urandom)};
      default: return 32'h8000_0000 + $urandom_range(0, 3) * 32'h10000
                      + {16'd0, 16'($urandom)} - 32'h20000 * $urandom_range(0, 1);
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    coord_valid <= 1;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (!coord_ready);
  endtask

  initial begin
    int burst;
    int gap;
    dir_x = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_0000,
              32'h7FFF_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000, 32'hAAAA_5555,
              32'h5555_AAAA, 32'h0000_FFFF, 32'h8000_0001, 32'h1234_4000, 32'hFFFE_C000};
    dir_y = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_8000,
              32'h7FFF_0000, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000, 32'h5555_AAAA,
              32'hAAAA_5555, 32'hFFFF_0001, 32'h7FFF_FFFF, 32'h0003_C000, 32'h0000_4000};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_x[i]) send_point(dir_x[i], dir_y[i]);
    for (int n = 0; n < N_RAND; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RAND; b++, n++) send_point(rand_coord(), rand_coord());
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        coord_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    coord_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d points: lattice edges, wrap cells, half offsets, random bursts",
             N_RAND + dir_x.size());
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/gn2_pkg.sv
rtl/gn2_corner.sv
rtl/gn2_weight.sv
rtl/gn2_mix.sv
rtl/gradient_noise_2d_top.sv
rtl/gn2_checker.sv
sim/gn2_checker.sv
sim/tb_top.sv
